// File: rtl/g57tr_pkg.sv
// ----------------------------------------------------------------------------
// g57tr_pkg: shared definitions for the 5x7 text rasterizer
// Widths, register indexes, microcode encoding, the program and the font ROM.
// ----------------------------------------------------------------------------
package g57tr_pkg;

	localparam int COORD_W    = 11;
	localparam int PEN_W      = 12;
	localparam int COLOR_W    = 16;
	localparam int CODE_W     = 8;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
	localparam int COL_W      = $clog2(GLYPH_COLS);
	localparam int ROW_W      = $clog2(GLYPH_ROWS);
	localparam int FIRST_CODE = 8'h20;
	localparam int LAST_CODE  = 8'h5A;
	localparam int GLYPH_CODES = LAST_CODE - FIRST_CODE + 1;
	localparam int GLYPH_IDX_W = $clog2(GLYPH_CODES);
	localparam int CHAR_ADVANCE = 6;
	localparam int PEN_MAX    = 2047;
	localparam int SCREEN_W_RESET = 320;
	localparam int SCREEN_H_RESET = 240;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_SCREEN_WIDTH  = 1'b0,
		CFG_SCREEN_HEIGHT = 1'b1
	} cfg_index_t;

	// Input item kinds.
	typedef enum logic [0:0] {
		KIND_SET_PEN = 1'b0,
		KIND_CHAR    = 1'b1
	} kind_t;

	// Program steps.
	typedef enum logic [1:0] {
		STEP_ACCEPT  = 2'd0,
		STEP_SCAN    = 2'd1,
		STEP_FLUSH   = 2'd2,
		STEP_ADVANCE = 2'd3
	} step_t;

	// Datapath operations, one per control word.
	typedef enum logic [1:0] {
		OP_ACCEPT  = 2'd0,
		OP_SCAN    = 2'd1,
		OP_FLUSH   = 2'd2,
		OP_ADVANCE = 2'd3
	} op_t;

	// Jump conditions: when true, the sequencer jumps to the target step,
	// otherwise it falls through to the next step.
	typedef enum logic [1:0] {
		COND_NEVER     = 2'd0,
		COND_ALWAYS    = 2'd1,
		COND_NO_CHAR   = 2'd2,
		COND_SCAN_MORE = 2'd3
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// Control from sequencer to datapath.
	typedef struct packed {
		op_t op;
	} ctrl_t;

	// Status from datapath to sequencer.
	typedef struct packed {
		logic char_fire;  // a character item was accepted this cycle
		logic scan_last;  // the scan position is on the last glyph bit
		logic hold;       // the current step cannot complete this cycle
	} flags_t;

	function automatic uword_t ucode(step_t step);
		uword_t w;
		unique case (step)
			STEP_ACCEPT:  w = '{op: OP_ACCEPT,  cond: COND_NO_CHAR,   target: STEP_ACCEPT};
			STEP_SCAN:    w = '{op: OP_SCAN,    cond: COND_SCAN_MORE, target: STEP_SCAN};
			STEP_FLUSH:   w = '{op: OP_FLUSH,   cond: COND_NEVER,     target: STEP_ACCEPT};
			STEP_ADVANCE: w = '{op: OP_ADVANCE, cond: COND_ALWAYS,    target: STEP_ACCEPT};
			default:      w = '{op: OP_ACCEPT,  cond: COND_NO_CHAR,   target: STEP_ACCEPT};
		endcase
		return w;
	endfunction

	// Font: column 0 in the top seven bits, column 4 in the bottom seven.
	// Within a column, bit 0 is the top row.
	localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_CODES] = '{
		{7'h00,7'h00,7'h00,7'h00,7'h00}, {7'h00,7'h00,7'h5F,7'h00,7'h00},
		{7'h00,7'h07,7'h00,7'h07,7'h00}, {7'h14,7'h7F,7'h14,7'h7F,7'h14},
		{7'h24,7'h2A,7'h7F,7'h2A,7'h12}, {7'h23,7'h13,7'h08,7'h64,7'h62},
		{7'h36,7'h49,7'h55,7'h22,7'h50}, {7'h00,7'h05,7'h03,7'h00,7'h00},
		{7'h00,7'h1C,7'h22,7'h41,7'h00}, {7'h00,7'h41,7'h22,7'h1C,7'h00},
		{7'h08,7'h2A,7'h1C,7'h2A,7'h08}, {7'h08,7'h08,7'h3E,7'h08,7'h08},
		{7'h00,7'h50,7'h30,7'h00,7'h00}, {7'h08,7'h08,7'h08,7'h08,7'h08},
		{7'h00,7'h60,7'h60,7'h00,7'h00}, {7'h20,7'h10,7'h08,7'h04,7'h02},
		{7'h3E,7'h51,7'h49,7'h45,7'h3E}, {7'h00,7'h42,7'h7F,7'h40,7'h00},
		{7'h42,7'h61,7'h51,7'h49,7'h46}, {7'h21,7'h41,7'h45,7'h4B,7'h31},
		{7'h18,7'h14,7'h12,7'h7F,7'h10}, {7'h27,7'h45,7'h45,7'h45,7'h39},
		{7'h3C,7'h4A,7'h49,7'h49,7'h30}, {7'h01,7'h71,7'h09,7'h05,7'h03},
		{7'h36,7'h49,7'h49,7'h49,7'h36}, {7'h06,7'h49,7'h49,7'h29,7'h1E},
		{7'h00,7'h36,7'h36,7'h00,7'h00}, {7'h00,7'h56,7'h36,7'h00,7'h00},
		{7'h00,7'h08,7'h14,7'h22,7'h41}, {7'h14,7'h14,7'h14,7'h14,7'h14},
		{7'h41,7'h22,7'h14,7'h08,7'h00}, {7'h02,7'h01,7'h51,7'h09,7'h06},
		{7'h32,7'h49,7'h79,7'h41,7'h3E}, {7'h7E,7'h11,7'h11,7'h11,7'h7E},
		{7'h7F,7'h49,7'h49,7'h49,7'h36}, {7'h3E,7'h41,7'h41,7'h41,7'h22},
		{7'h7F,7'h41,7'h41,7'h22,7'h1C}, {7'h7F,7'h49,7'h49,7'h49,7'h41},
		{7'h7F,7'h09,7'h09,7'h01,7'h01}, {7'h3E,7'h41,7'h41,7'h51,7'h32},
		{7'h7F,7'h08,7'h08,7'h08,7'h7F}, {7'h00,7'h41,7'h7F,7'h41,7'h00},
		{7'h20,7'h40,7'h41,7'h3F,7'h01}, {7'h7F,7'h08,7'h14,7'h22,7'h41},
		{7'h7F,7'h40,7'h40,7'h40,7'h40}, {7'h7F,7'h02,7'h04,7'h02,7'h7F},
		{7'h7F,7'h04,7'h08,7'h10,7'h7F}, {7'h3E,7'h41,7'h41,7'h41,7'h3E},
		{7'h7F,7'h09,7'h09,7'h09,7'h06}, {7'h3E,7'h41,7'h51,7'h21,7'h5E},
		{7'h7F,7'h09,7'h19,7'h29,7'h46}, {7'h46,7'h49,7'h49,7'h49,7'h31},
		{7'h01,7'h01,7'h7F,7'h01,7'h01}, {7'h3F,7'h40,7'h40,7'h40,7'h3F},
		{7'h1F,7'h20,7'h40,7'h20,7'h1F}, {7'h7F,7'h20,7'h18,7'h20,7'h7F},
		{7'h63,7'h14,7'h08,7'h14,7'h63}, {7'h03,7'h04,7'h78,7'h04,7'h03},
		{7'h61,7'h51,7'h49,7'h45,7'h43}
	};

	// Glyph bits of a code; codes outside the font give an empty glyph.
	function automatic logic [GLYPH_BITS-1:0] glyph_bits(logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] offs;
		offs = code - CODE_W'(FIRST_CODE);
		if (code >= CODE_W'(FIRST_CODE) && code <= CODE_W'(LAST_CODE)) begin
			return GLYPH_ROM[offs[GLYPH_IDX_W-1:0]];
		end
		return '0;
	endfunction

endpackage

// File: rtl/g57tr_if.sv
// ----------------------------------------------------------------------------
// g57tr_if: channel interfaces of the 5x7 text rasterizer
// Input item channel and pixel write channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface g57tr_item_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [g57tr_pkg::PEN_W-1:0]     pen_x_in;
	logic [g57tr_pkg::PEN_W-1:0]     pen_y_in;
	logic [g57tr_pkg::COLOR_W-1:0]   ink_in;
	logic [g57tr_pkg::CODE_W-1:0]    char_code;

	modport source (output valid, kind, pen_x_in, pen_y_in, ink_in, char_code,
		input ready);
	modport sink (input valid, kind, pen_x_in, pen_y_in, ink_in, char_code,
		output ready);
endinterface

interface g57tr_pixel_if;
	logic                            valid;
	logic                            ready;
	logic [g57tr_pkg::COORD_W-1:0]   pixel_x;
	logic [g57tr_pkg::COORD_W-1:0]   pixel_y;
	logic [g57tr_pkg::COLOR_W-1:0]   pixel_color;
	logic                            last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
		output ready);
endinterface

// File: rtl/g57tr_seq.sv
// ----------------------------------------------------------------------------
// g57tr_seq: microcode sequencer
// Step counter over the control program, with conditional jumps and hold.
// ----------------------------------------------------------------------------
module g57tr_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  g57tr_pkg::flags_t flags,
	output g57tr_pkg::ctrl_t  ctrl
);
	import g57tr_pkg::*;

	step_t  step_q;
	step_t  step_d;
	uword_t uw;
	logic   jump;

	assign uw = ucode(step_q);
	assign ctrl.op = uw.op;

	always_comb begin
		unique case (uw.cond)
			COND_NEVER:     jump = 1'b0;
			COND_ALWAYS:    jump = 1'b1;
			COND_NO_CHAR:   jump = !flags.char_fire;
			COND_SCAN_MORE: jump = !flags.scan_last;
			default:        jump = 1'b0;
		endcase
	end

	always_comb begin
		if (flags.hold) begin
			step_d = step_q;
		end else if (jump) begin
			step_d = uw.target;
		end else begin
			step_d = step_t'(step_q + 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_ACCEPT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// File: rtl/g57tr_dp.sv
// ----------------------------------------------------------------------------
// g57tr_dp: rasterizer datapath
// Pen state, glyph scan position, clipping, one pending pixel and the
// output register.
// ----------------------------------------------------------------------------
module g57tr_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  g57tr_pkg::ctrl_t              ctrl,
	output g57tr_pkg::flags_t             flags,
	input  logic [g57tr_pkg::COORD_W-1:0] screen_width,
	input  logic [g57tr_pkg::COORD_W-1:0] screen_height,
	g57tr_item_if.sink                    item,
	g57tr_pixel_if.source                 pixel
);
	import g57tr_pkg::*;

	logic signed [PEN_W-1:0]  pen_col_q;
	logic signed [PEN_W-1:0]  pen_row_q;
	logic [COLOR_W-1:0]       ink_q;
	logic [GLYPH_BITS-1:0]    glyph_q;
	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         row_q;

	// Pending pixel: held back until it is known whether it is the last.
	logic                     pend_v_q;
	logic [COORD_W-1:0]       pend_x_q;
	logic [COORD_W-1:0]       pend_y_q;

	logic                     out_v_q;
	logic [COORD_W-1:0]       out_x_q;
	logic [COORD_W-1:0]       out_y_q;
	logic [COLOR_W-1:0]       out_c_q;
	logic                     out_last_q;

	logic                     fire;
	logic                     out_free;
	logic [GLYPH_ROWS-1:0]    col_bits;
	logic signed [PEN_W:0]    px;
	logic signed [PEN_W:0]    py;
	logic signed [PEN_W:0]    adv;
	logic                     hit;
	logic                     scan_go;
	logic                     flush_go;
	logic                     scan_last;

	assign item.ready = (ctrl.op == OP_ACCEPT);
	assign fire       = item.valid && item.ready;
	assign out_free   = !out_v_q || pixel.ready;

	assign col_bits = glyph_q[(GLYPH_COLS - 1 - int'(col_q)) * GLYPH_ROWS +: GLYPH_ROWS];
	assign px  = $signed({pen_col_q[PEN_W-1], pen_col_q}) + $signed({1'b0, PEN_W'(col_q)});
	assign py  = $signed({pen_row_q[PEN_W-1], pen_row_q}) + $signed({1'b0, PEN_W'(row_q)});
	assign hit = col_bits[row_q] && !px[PEN_W] && !py[PEN_W]
		&& (px < $signed({2'b00, screen_width}))
		&& (py < $signed({2'b00, screen_height}));

	assign scan_last = (col_q == COL_W'(GLYPH_COLS - 1)) && (row_q == ROW_W'(GLYPH_ROWS - 1));
	assign scan_go   = (ctrl.op == OP_SCAN) && !(hit && pend_v_q && !out_free);
	assign flush_go  = (ctrl.op == OP_FLUSH) && !(pend_v_q && !out_free);
	assign adv       = $signed({pen_col_q[PEN_W-1], pen_col_q}) + (PEN_W+1)'(CHAR_ADVANCE);

	assign flags.char_fire = fire && (item.kind == KIND_CHAR);
	assign flags.scan_last = scan_last;
	assign flags.hold      = ((ctrl.op == OP_SCAN) && !scan_go)
		|| ((ctrl.op == OP_FLUSH) && !flush_go);

	// Pen, ink and glyph registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_col_q <= '0;
			pen_row_q <= '0;
			ink_q     <= '0;
		end else begin
			if (fire && item.kind == KIND_SET_PEN) begin
				pen_col_q <= item.pen_x_in;
				pen_row_q <= item.pen_y_in;
				ink_q     <= item.ink_in;
			end else if (ctrl.op == OP_ADVANCE) begin
				if (adv > $signed((PEN_W+1)'(PEN_MAX))) begin
					pen_col_q <= PEN_W'(PEN_MAX);
				end else begin
					pen_col_q <= adv[PEN_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item.kind == KIND_CHAR) begin
			glyph_q <= glyph_bits(item.char_code);
		end
	end

	// Scan position: rows top to bottom within a column, then the next column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (fire) begin
				col_q <= '0;
				row_q <= '0;
			end else if (scan_go && !scan_last) begin
				if (row_q == ROW_W'(GLYPH_ROWS - 1)) begin
					row_q <= '0;
					col_q <= col_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
		end
	end

	// Pending pixel and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (scan_go && hit) begin
				pend_v_q <= 1'b1;
			end else if (flush_go) begin
				pend_v_q <= 1'b0;
			end
			if ((scan_go && hit && pend_v_q) || (flush_go && pend_v_q)) begin
				out_v_q <= 1'b1;
			end else if (pixel.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_go && hit) begin
			pend_x_q <= px[COORD_W-1:0];
			pend_y_q <= py[COORD_W-1:0];
		end
		if ((scan_go && hit && pend_v_q) || (flush_go && pend_v_q)) begin
			out_x_q    <= pend_x_q;
			out_y_q    <= pend_y_q;
			out_c_q    <= ink_q;
			out_last_q <= flush_go;
		end
	end

	assign pixel.valid       = out_v_q;
	assign pixel.pixel_x     = out_x_q;
	assign pixel.pixel_y     = out_y_q;
	assign pixel.pixel_color = out_c_q;
	assign pixel.last_pixel  = out_last_q;

endmodule

// File: rtl/glyph_5x7_text_rasterizer_top.sv
// ----------------------------------------------------------------------------
// glyph_5x7_text_rasterizer_top: 5x7 text overlay rasterizer
// Draws characters from a fixed 5x7 font as clipped pixel writes.
//
//   channel   direction   handshake      beat carries
//   item      in          valid/ready    kind, pen_x_in, pen_y_in, ink_in,
//                                        char_code
//   pixel     out         valid/ready    pixel_x, pixel_y, pixel_color,
//                                        last_pixel
//   cfg       in          cfg_we only    cfg_index, cfg_wdata
//
// A set-pen beat is taken in the accept step alone. A character beat runs
// through the accept step, the scan of the glyph one bit per cycle while the
// scan is not held, the release of the held-back last pixel and the advance
// of the pen. A stalled pixel channel holds the scan when a new visible
// pixel finds both the held-back pixel and the output register full, and
// holds the release step while a pixel is held back and the register is full.
// Reset clears the pen and ink to zero and sets the screen to 320 by 240.
// ----------------------------------------------------------------------------
module glyph_5x7_text_rasterizer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [g57tr_pkg::COORD_W-1:0] cfg_wdata,
	g57tr_item_if.sink                    item_ch,
	g57tr_pixel_if.source                 pixel_ch
);
	import g57tr_pkg::*;

	// Screen size registers. They are to be written only while the block is idle; the block does not enforce it.
	logic [COORD_W-1:0] screen_width_q;
	logic [COORD_W-1:0] screen_height_q;

	ctrl_t  ctrl;
	flags_t flags;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= COORD_W'(SCREEN_W_RESET);
			screen_height_q <= COORD_W'(SCREEN_H_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata;
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata;
				default:           ;
			endcase
		end
	end

	// The sequencer steps through the control program; the datapath carries
	// out one operation per control word and reports the jump and hold flags.
	g57tr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	g57tr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.flags         (flags),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.item          (item_ch),
		.pixel         (pixel_ch)
	);

endmodule
